/* hdl/lhp_pkg.sv */
// Shared types and constants for the latency histogram monitor.
// No dependencies; imported by lhp_store and latency_histogram_percentile_top.
package lhp_pkg;

  localparam int NUM_BUCKETS_DEF  = 1024;
  localparam int CLAMP_MICROS_DEF = 1024;

  localparam int TIME_W = 64;
  localparam int CNT_W  = 48;
  localparam int PM_W   = 10;
  localparam int BIDX_W = 10;
  localparam int PCT_W  = 20;
  localparam int BKT_W  = 32;

  localparam int NS_PER_US      = 1000;
  localparam int PER_MILLE_FULL = 1000;

  // Latencies below the clamp limit fit in DIV_W bits (2^DIV_W ns is about 67108 us).
  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x < 2^DIV_W.
  localparam int          DIV_W       = 26;
  localparam int          RECIP_W     = 28;
  localparam int          RECIP_SHIFT = 37;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 28'd137438954;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_REC_LAT,
    ST_REC_BIN,
    ST_REC_RD,
    ST_REC_WR,
    ST_QRY_SETUP,
    ST_PCT_RD,
    ST_PCT_MUL,
    ST_PCT_ADD,
    ST_PCT_CMP,
    ST_BKT_RD,
    ST_CLEAR,
    ST_FINISH
  } state_t;

endpackage

/* hdl/lhp_store.sv */
// Single-port bucket memory with registered read data.
// Depends on lhp_pkg for the bucket width.
module lhp_store
  import lhp_pkg::*;
#(
  parameter int DEPTH = NUM_BUCKETS_DEF,
  parameter int AW    = $clog2(NUM_BUCKETS_DEF)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [BKT_W-1:0] wdata,
  output logic [BKT_W-1:0] rdata
);

  logic [BKT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/latency_histogram_percentile_top.sv */
// Latency histogram monitor: record, percentile query, bucket read, clear.
// Depends on lhp_pkg and lhp_store (bucket memory, one access per cycle).
// Steps from accept to done: record finds the latency and its bucket, then reads
//   and writes that bucket (not if end is not after start); read bucket reads once;
//   query (unless empty) reads and adds bucket by bucket until hit; clear zeroes all.
// One item at a time; busy is high until the done cycle, when a new item may start.
// Each result is strobed on done for one cycle; the receiver cannot stall it.
// Synchronous reset runs a zeroing pass over the buckets with busy high.
module latency_histogram_percentile_top
  import lhp_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int CLAMP_MICROS = CLAMP_MICROS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [TIME_W-1:0] enter_ts,
  input  logic [TIME_W-1:0] exit_ts,
  input  logic [PM_W-1:0]   fraction_per_mille,
  input  logic [BIDX_W-1:0] bin_addr,
  output logic              done,
  output logic              accepted,
  output logic [CNT_W-1:0]  sample_count,
  output logic [TIME_W-1:0] min_latency,
  output logic [TIME_W-1:0] max_latency,
  output logic [TIME_W-1:0] total_latency,
  output logic [PCT_W-1:0]  percentile_latency,
  output logic [BKT_W-1:0]  bucket_value
);

  localparam int IDX_W   = $clog2(NUM_BUCKETS);
  localparam int LIMIT   = (CLAMP_MICROS < NUM_BUCKETS) ? CLAMP_MICROS : NUM_BUCKETS;
  localparam logic [TIME_W-1:0] LIMIT_NS = TIME_W'(LIMIT) * TIME_W'(NS_PER_US);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
  localparam int QP_W    = DIV_W + RECIP_W;
  localparam int TGT_W   = CNT_W + PM_W;
  localparam int SCL_W   = BKT_W + 10;
  localparam int RUN_W   = BKT_W + IDX_W + 11;
  localparam int CMP_W   = (RUN_W > TGT_W) ? RUN_W : TGT_W;
  localparam int PCTP_W  = IDX_W + 10;

  state_t state, state_next;

  // item registers
  logic [1:0]        mode_r;
  logic [TIME_W-1:0] t0, t1;
  logic [PM_W-1:0]   pm_r;
  logic [BIDX_W-1:0] bidx_r;

  // record path
  logic [TIME_W-1:0] lat;
  logic              lat_ok;
  logic              over_lim;
  logic [QP_W-1:0]   quot_prod;
  logic [IDX_W-1:0]  slot, slot_c;

  // percentile walk
  logic [TGT_W-1:0]  tgt;
  logic [SCL_W-1:0]  scaled;
  logic [RUN_W-1:0]  run;
  logic [IDX_W-1:0]  ptr;
  logic              hit, last;
  logic [PCTP_W-1:0] pct_prod;
  logic              in_range;

  // statistics
  logic [CNT_W-1:0]  samples;
  logic [TIME_W-1:0] sum, smallest, largest;

  // memory port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [BKT_W-1:0]  ram_wdata, ram_rdata;

  lhp_store #(
    .DEPTH(NUM_BUCKETS),
    .AW   (IDX_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign busy     = (state != ST_IDLE);
  assign slot_c   = over_lim ? LAST_IDX : IDX_W'(quot_prod >> RECIP_SHIFT);
  assign hit      = CMP_W'(run) > CMP_W'(tgt);
  assign last     = (ptr == LAST_IDX);
  assign pct_prod = PCTP_W'(ptr) * PCTP_W'(NS_PER_US);
  assign in_range = 32'(bidx_r) < 32'(NUM_BUCKETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = '0;
    ram_wdata  = '0;
    case (state)
      ST_INIT: begin
        ram_we   = 1'b1;
        ram_addr = ptr;
        if (last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_RECORD: state_next = ST_REC_LAT;
            MODE_QUERY:  state_next = ST_QRY_SETUP;
            MODE_READ:   state_next = ST_BKT_RD;
            MODE_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_REC_LAT: state_next = ST_REC_BIN;
      ST_REC_BIN: state_next = lat_ok ? ST_REC_RD : ST_FINISH;
      ST_REC_RD: begin
        ram_addr   = slot_c;
        state_next = ST_REC_WR;
      end
      ST_REC_WR: begin
        ram_we     = 1'b1;
        ram_addr   = slot;
        // saturate the bucket
        ram_wdata  = (ram_rdata == '1) ? ram_rdata : ram_rdata + BKT_W'(1);
        state_next = ST_FINISH;
      end
      ST_QRY_SETUP: state_next = (samples == '0) ? ST_FINISH : ST_PCT_RD;
      ST_PCT_RD: begin
        ram_addr   = ptr;
        state_next = ST_PCT_MUL;
      end
      ST_PCT_MUL: state_next = ST_PCT_ADD;
      ST_PCT_ADD: state_next = ST_PCT_CMP;
      ST_PCT_CMP: state_next = (hit || last) ? ST_FINISH : ST_PCT_RD;
      ST_BKT_RD: begin
        ram_addr   = IDX_W'(bidx_r);
        state_next = ST_FINISH;
      end
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = ptr;
        if (last) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      ptr      <= '0;
      samples  <= '0;
      sum      <= '0;
      smallest <= '1;
      largest  <= '0;
    end else begin
      done <= (state == ST_FINISH);
      case (state)
        ST_INIT, ST_CLEAR: ptr <= ptr + IDX_W'(1);
        ST_IDLE: begin
          if (start) begin
            mode_r <= mode;
            t0     <= enter_ts;
            t1     <= exit_ts;
            pm_r   <= (fraction_per_mille > PM_W'(PER_MILLE_FULL)) ?
                      PM_W'(PER_MILLE_FULL) : fraction_per_mille;
            bidx_r <= bin_addr;
            ptr    <= '0;
            if (mode == MODE_CLEAR) begin
              samples  <= '0;
              sum      <= '0;
              smallest <= '1;
              largest  <= '0;
            end
          end
        end
        ST_REC_LAT: begin
          lat    <= t1 - t0;
          lat_ok <= (t1 > t0);
        end
        ST_REC_BIN: begin
          over_lim  <= (lat >= LIMIT_NS);
          quot_prod <= QP_W'(lat[DIV_W-1:0]) * QP_W'(RECIP_1000);
        end
        ST_REC_RD: slot <= slot_c;
        ST_REC_WR: begin
          if (samples != '1) samples <= samples + CNT_W'(1);
          sum <= sum + lat;
          if (lat < smallest) smallest <= lat;
          if (lat > largest)  largest  <= lat;
        end
        ST_QRY_SETUP: begin
          tgt <= TGT_W'(samples) * TGT_W'(pm_r);
          // run holds 1000 * (running count + 1): compare with count*f skips the divide
          run <= RUN_W'(NS_PER_US);
        end
        ST_PCT_MUL: scaled <= SCL_W'(ram_rdata) * SCL_W'(NS_PER_US);
        ST_PCT_ADD: run <= run + RUN_W'(scaled);
        ST_PCT_CMP: if (!(hit || last)) ptr <= ptr + IDX_W'(1);
        ST_FINISH: begin
          accepted           <= (mode_r == MODE_RECORD) && lat_ok;
          sample_count       <= samples;
          min_latency        <= (samples == '0) ? '0 : smallest;
          max_latency        <= largest;
          total_latency      <= sum;
          percentile_latency <= (mode_r == MODE_QUERY) ? PCT_W'(pct_prod) : '0;
          bucket_value       <= ((mode_r == MODE_READ) && in_range) ? ram_rdata : '0;
        end
        default: ;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobed while still busy");

  a_acc_count: assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> (sample_count != '0)) else $error("accepted with zero count");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (done && sample_count != '0) |-> (min_latency <= max_latency))
    else $error("min latency above max latency");

endmodule
